/* rtl/cbt_pkg.sv */
// shared types, constants and helper functions of the cubic bezier tessellator
`timescale 1ns / 1ps

package cbt_pkg;

	localparam int SEC_W        = 6;
	localparam int MAX_SECTIONS = 63;
	localparam int COORD_W      = 24;
	localparam int T_W          = 16;
	localparam int U_W          = T_W + 1;
	localparam int T2_W         = 2 * T_W;
	localparam int U2_W         = 2 * T_W + 1;
	localparam int W_W          = 3 * T_W + 1;
	localparam int HALF_W       = 24;
	localparam int DIV_STEP     = 8;

	localparam logic [SEC_W-1:0] SECTIONS_RESET = SEC_W'(6);
	localparam logic [SEC_W-1:0] SECTIONS_MAX   = SEC_W'(MAX_SECTIONS);

	typedef logic signed [COORD_W-1:0] cbt_coord_t;

	// one input beat: a cubic segment
	typedef struct packed {
		cbt_coord_t start_x;
		cbt_coord_t start_y;
		cbt_coord_t ctrl1_x;
		cbt_coord_t ctrl1_y;
		cbt_coord_t ctrl2_x;
		cbt_coord_t ctrl2_y;
		cbt_coord_t end_x;
		cbt_coord_t end_y;
		logic       last_segment;
	} cbt_seg_t;

	// one output beat: a curve point
	typedef struct packed {
		cbt_coord_t point_x;
		cbt_coord_t point_y;
		logic       end_of_run;
	} cbt_pt_t;

	// work token that travels down the pipeline with its valid bit
	typedef struct packed {
		cbt_seg_t         seg;
		logic [SEC_W-1:0] k;
		logic [SEC_W-1:0] n;
		logic             is_end;
		logic             eor;
	} cbt_tok_t;

	typedef logic [W_W-1:0]        cbt_wgt_t;
	typedef logic [3:0][W_W-1:0]   cbt_wgts_t;

	typedef struct packed {
		logic [DIV_STEP-1:0] q;
		logic [SEC_W-1:0]    r;
	} cbt_div_t;

	// eight restoring division steps, remainder stays below the divisor
	function automatic cbt_div_t cbt_div8(input logic [SEC_W-1:0] r_in,
		input logic [SEC_W-1:0] d);
		cbt_div_t       res;
		logic [SEC_W:0] r2;
		res.r = r_in;
		res.q = '0;
		for (int j = 0; j < DIV_STEP; j++) begin
			r2 = {res.r, 1'b0};
			if (r2 >= {1'b0, d}) begin
				r2    = r2 - {1'b0, d};
				res.q = {res.q[DIV_STEP-2:0], 1'b1};
			end else begin
				res.q = {res.q[DIV_STEP-2:0], 1'b0};
			end
			res.r = r2[SEC_W-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/cubic_bezier_tessellator.sv */
// top level of the cubic bezier tessellator
`timescale 1ns / 1ps

//  channel    dir  handshake              beat
//  seg        in   seg_valid / seg_stall  one cubic segment, four q15.8 points
//  pt         out  pt_valid  / pt_stall   one curve point with end_of_run
//  sections   in   sections_we            6-bit point count per segment
//
//  a segment gives n points at the sequencer (n = sections, zero read as one),
//  one more when last_segment is set for the exact end point; one point per cycle
//  when not stalled; the next segment is taken in the cycle its predecessor
//  issues its final point; issued points pass division, weights and blend
//  reset clears all valid bits and loads sections with six
//  pt_stall with pt_valid freezes every stage; no beat is lost or repeated

module cubic_bezier_tessellator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      seg_valid,
	output logic                      seg_stall,
	input  cbt_pkg::cbt_seg_t         seg,
	output logic                      pt_valid,
	input  logic                      pt_stall,
	output cbt_pkg::cbt_pt_t          pt,
	input  logic                      sections_we,
	input  logic [cbt_pkg::SEC_W-1:0] sections_wdata
);
	import cbt_pkg::*;

	logic [SEC_W-1:0] sections_q;
	logic             adv;
	logic             v_s1, v_s6, v_s9;
	cbt_tok_t         tok_s1, tok_s6;
	cbt_wgts_t        w_s6;
	cbt_pt_t          pt_s9;

	// sections register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sections_q <= SECTIONS_RESET;
		end else if (sections_we) begin
			sections_q <= sections_wdata;
		end
	end

	// whole pipeline moves unless a finished point is held at the output
	assign adv = !(v_s9 && pt_stall);

	// stage 1: sequencer walks k over the held segment
	cbt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.sections  (sections_q),
		.adv       (adv),
		.v_s1      (v_s1),
		.tok_s1    (tok_s1)
	);

	// stages 2 to 6: t from long division, then the weights in q1.48
	cbt_param u_param (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_s1   (v_s1),
		.tok_s1 (tok_s1),
		.v_s6   (v_s6),
		.tok_s6 (tok_s6),
		.w_s6   (w_s6)
	);

	// stages 7 to 9: split products, sums, floor to q15.8 into the output register
	cbt_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_s6   (v_s6),
		.tok_s6 (tok_s6),
		.w_s6   (w_s6),
		.v_s9   (v_s9),
		.pt_s9  (pt_s9)
	);

	assign pt_valid = v_s9;
	assign pt       = pt_s9;

endmodule

/* rtl/cbt_seq.sv */
// segment holding register and point sequencer, feeds pipeline stage 1
`timescale 1ns / 1ps

module cbt_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     seg_valid,
	output logic                     seg_stall,
	input  cbt_pkg::cbt_seg_t        seg,
	input  logic [cbt_pkg::SEC_W-1:0] sections,
	input  logic                     adv,
	output logic                     v_s1,
	output cbt_pkg::cbt_tok_t        tok_s1
);
	import cbt_pkg::*;

	cbt_seg_t         seg_q;
	logic             vld_q;
	logic [SEC_W-1:0] k_q;
	logic [SEC_W-1:0] n_q;
	logic             end_ph_q;
	logic [SEC_W-1:0] n_clamp;
	logic             last_k;
	logic             fin;
	logic             issue;
	logic             accept;

	// zero sections acts as one
	always_comb begin
		if (sections == '0) begin
			n_clamp = SEC_W'(1);
		end else if (sections > SECTIONS_MAX) begin
			n_clamp = SECTIONS_MAX;
		end else begin
			n_clamp = sections;
		end
	end

	assign last_k    = (k_q == n_q - SEC_W'(1));
	assign fin       = end_ph_q || (last_k && !seg_q.last_segment);
	assign issue     = vld_q && adv;
	assign seg_stall = vld_q && !(issue && fin);
	assign accept    = seg_valid && !seg_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= 1'b0;
			k_q      <= '0;
			end_ph_q <= 1'b0;
		end else if (accept) begin
			vld_q    <= 1'b1;
			k_q      <= '0;
			end_ph_q <= 1'b0;
		end else if (issue) begin
			if (fin) begin
				vld_q <= 1'b0;
			end else if (last_k) begin
				end_ph_q <= 1'b1;
			end else begin
				k_q <= k_q + SEC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_q <= seg;
			n_q   <= n_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1.seg    <= seg_q;
			tok_s1.k      <= k_q;
			tok_s1.n      <= n_q;
			tok_s1.is_end <= end_ph_q;
			tok_s1.eor    <= fin;
		end
	end

endmodule

/* rtl/cbt_param.sv */
// parameter t = k*65536/n by pipelined long division, then the four bernstein weights
`timescale 1ns / 1ps

module cbt_param (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_s1,
	input  cbt_pkg::cbt_tok_t  tok_s1,
	output logic               v_s6,
	output cbt_pkg::cbt_tok_t  tok_s6,
	output cbt_pkg::cbt_wgts_t w_s6
);
	import cbt_pkg::*;

	logic                v_s2, v_s3, v_s4, v_s5;
	cbt_tok_t            tok_s2, tok_s3, tok_s4, tok_s5;
	cbt_div_t            dh, dl;
	logic [DIV_STEP-1:0] qh_s2;
	logic [SEC_W-1:0]    r_s2;
	logic [T_W-1:0]      t_s3;
	logic [U_W-1:0]      u;
	logic [2*U_W-1:0]    u2_full;
	logic [T_W-1:0]      t_s4;
	logic [U_W-1:0]      u_s4;
	logic [T2_W-1:0]     t2_s4;
	logic [U2_W-1:0]     u2_s4;
	logic [U2_W+U_W-1:0] w0_full;
	logic [U2_W+T_W-1:0] tu2_full;
	logic [T2_W+U_W-1:0] t2u_full;
	logic [T2_W+T_W-1:0] w3_full;
	cbt_wgt_t            w0_s5, tu2_s5, t2u_s5, w3_s5;
	logic [W_W+1:0]      w1_full, w2_full;

	// high and low quotient bytes, remainder starts at k since k < n
	assign dh = cbt_div8(tok_s1.k, tok_s1.n);
	assign dl = cbt_div8(r_s2, tok_s2.n);

	assign u        = U_W'(1 << T_W) - {1'b0, t_s3};
	assign u2_full  = u * u;
	assign w0_full  = u2_s4 * u_s4;
	assign tu2_full = u2_s4 * t_s4;
	assign t2u_full = t2_s4 * u_s4;
	assign w3_full  = t2_s4 * t_s4;
	assign w1_full  = {2'b00, tu2_s5} + {1'b0, tu2_s5, 1'b0};
	assign w2_full  = {2'b00, t2u_s5} + {1'b0, t2u_s5, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2 <= tok_s1;
			qh_s2  <= dh.q;
			r_s2   <= dh.r;

			tok_s3 <= tok_s2;
			t_s3   <= {qh_s2, dl.q};

			tok_s4 <= tok_s3;
			t_s4   <= t_s3;
			u_s4   <= u;
			t2_s4  <= t_s3 * t_s3;
			u2_s4  <= u2_full[U2_W-1:0];

			tok_s5 <= tok_s4;
			w0_s5  <= w0_full[W_W-1:0];
			tu2_s5 <= tu2_full[W_W-1:0];
			t2u_s5 <= t2u_full[W_W-1:0];
			w3_s5  <= w3_full[W_W-1:0];

			tok_s6  <= tok_s5;
			w_s6[0] <= w0_s5;
			w_s6[1] <= w1_full[W_W-1:0];
			w_s6[2] <= w2_full[W_W-1:0];
			w_s6[3] <= w3_s5;
		end
	end

endmodule

/* rtl/cbt_blend.sv */
// weighted sum of the control points, floored back to q15.8
`timescale 1ns / 1ps

module cbt_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_s6,
	input  cbt_pkg::cbt_tok_t  tok_s6,
	input  cbt_pkg::cbt_wgts_t w_s6,
	output logic               v_s9,
	output cbt_pkg::cbt_pt_t   pt_s9
);
	import cbt_pkg::*;

	localparam int PH_W = W_W - HALF_W + 1 + COORD_W;
	localparam int PL_W = HALF_W + 1 + COORD_W;
	localparam int SH_W = PH_W + 2;
	localparam int SL_W = PL_W + 2;

	cbt_coord_t               px [4];
	cbt_coord_t               py [4];
	logic                     v_s7, v_s8;
	cbt_tok_t                 tok_s7, tok_s8;
	logic signed [PH_W-1:0]   phx_s7 [4];
	logic signed [PH_W-1:0]   phy_s7 [4];
	logic signed [PL_W-1:0]   plx_s7 [4];
	logic signed [PL_W-1:0]   ply_s7 [4];
	logic signed [SH_W-1:0]   hx_s8, hy_s8;
	logic signed [SL_W-1:0]   lx_s8, ly_s8;
	logic signed [SH_W-1:0]   totx, toty;

	always_comb begin
		px[0] = tok_s6.seg.start_x;
		px[1] = tok_s6.seg.ctrl1_x;
		px[2] = tok_s6.seg.ctrl2_x;
		px[3] = tok_s6.seg.end_x;
		py[0] = tok_s6.seg.start_y;
		py[1] = tok_s6.seg.ctrl1_y;
		py[2] = tok_s6.seg.ctrl2_y;
		py[3] = tok_s6.seg.end_y;
	end

	// high half carries the low half's floored contribution
	assign totx = hx_s8 + (lx_s8 >>> HALF_W);
	assign toty = hy_s8 + (ly_s8 >>> HALF_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s7 <= tok_s6;
			for (int i = 0; i < 4; i++) begin
				phx_s7[i] <= $signed({1'b0, w_s6[i][W_W-1:HALF_W]}) * px[i];
				phy_s7[i] <= $signed({1'b0, w_s6[i][W_W-1:HALF_W]}) * py[i];
				plx_s7[i] <= $signed({1'b0, w_s6[i][HALF_W-1:0]}) * px[i];
				ply_s7[i] <= $signed({1'b0, w_s6[i][HALF_W-1:0]}) * py[i];
			end

			tok_s8 <= tok_s7;
			hx_s8  <= SH_W'(phx_s7[0]) + SH_W'(phx_s7[1]) + SH_W'(phx_s7[2])
				+ SH_W'(phx_s7[3]);
			hy_s8  <= SH_W'(phy_s7[0]) + SH_W'(phy_s7[1]) + SH_W'(phy_s7[2])
				+ SH_W'(phy_s7[3]);
			lx_s8  <= SL_W'(plx_s7[0]) + SL_W'(plx_s7[1]) + SL_W'(plx_s7[2])
				+ SL_W'(plx_s7[3]);
			ly_s8  <= SL_W'(ply_s7[0]) + SL_W'(ply_s7[1]) + SL_W'(ply_s7[2])
				+ SL_W'(ply_s7[3]);

			pt_s9.end_of_run <= tok_s8.eor;
			if (tok_s8.is_end) begin
				pt_s9.point_x <= tok_s8.seg.end_x;
				pt_s9.point_y <= tok_s8.seg.end_y;
			end else begin
				pt_s9.point_x <= totx[HALF_W+COORD_W-1:HALF_W];
				pt_s9.point_y <= toty[HALF_W+COORD_W-1:HALF_W];
			end
		end
	end

endmodule
